// File: hw/rtl/kalman_altitude_velocity_bias_defines.svh
// assertion macros for the altitude kalman filter
`ifndef KALMAN_ALTITUDE_VELOCITY_BIAS_DEFINES_SVH
`define KALMAN_ALTITUDE_VELOCITY_BIAS_DEFINES_SVH

// implication checked on every clock edge outside reset
`define KAVB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication checked outside reset
`define KAVB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/kavb_pkg.sv
// package: word format, register indexes, opcodes and controller types
package kavb_pkg;

	localparam int WORD_BITS_DEF = 48;
	localparam int FRAC_BITS_DEF = 24;
	localparam int CFG_IDX_BITS  = 2;

	localparam logic [CFG_IDX_BITS-1:0] REG_STEP_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MEAS_VAR      = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_ACCEL_VAR     = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_BIAS_VAR      = 2'd3;

	// register file slots of the datapath
	localparam int NREG      = 32;
	localparam int RADDR_W   = 5;
	typedef logic [RADDR_W-1:0] raddr_t;

	localparam raddr_t R_P0  = 5'd0;
	localparam raddr_t R_P1  = 5'd1;
	localparam raddr_t R_P2  = 5'd2;
	localparam raddr_t R_P3  = 5'd3;
	localparam raddr_t R_P4  = 5'd4;
	localparam raddr_t R_P5  = 5'd5;
	localparam raddr_t R_P6  = 5'd6;
	localparam raddr_t R_P7  = 5'd7;
	localparam raddr_t R_P8  = 5'd8;
	localparam raddr_t R_Z   = 5'd9;
	localparam raddr_t R_V   = 5'd10;
	localparam raddr_t R_B   = 5'd11;
	localparam raddr_t R_DT  = 5'd12;
	localparam raddr_t R_RV  = 5'd13;
	localparam raddr_t R_QA  = 5'd14;
	localparam raddr_t R_QB  = 5'd15;
	localparam raddr_t R_DT2 = 5'd16;
	localparam raddr_t R_H   = 5'd17;
	localparam raddr_t R_Q3  = 5'd18;
	localparam raddr_t R_Q4  = 5'd19;
	localparam raddr_t R_ZM  = 5'd20;
	localparam raddr_t R_AM  = 5'd21;
	localparam raddr_t R_T0  = 5'd22;
	localparam raddr_t R_T1  = 5'd23;
	localparam raddr_t R_T2  = 5'd24;
	localparam raddr_t R_IN  = 5'd25;
	localparam raddr_t R_DEN = 5'd26;
	localparam raddr_t R_KZ  = 5'd27;
	localparam raddr_t R_KV  = 5'd28;
	localparam raddr_t R_KA  = 5'd29;
	localparam raddr_t R_X   = 5'd30;
	localparam raddr_t R_Y   = 5'd31;

	// datapath operations
	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_HALF = 3'd4,
		OP_MOV  = 3'd5
	} op_t;

	typedef struct packed {
		logic   start;
		op_t    op;
		raddr_t a;
		raddr_t b;
		raddr_t d;
	} cmd_t;

	typedef struct packed {
		logic busy;
	} sts_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_LOAD = 5'b00010,
		ST_ISS  = 5'b00100,
		ST_WAIT = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	localparam int NPROG  = 78;
	localparam int PC_W   = 7;

	typedef struct packed {
		op_t    op;
		raddr_t a;
		raddr_t b;
		raddr_t d;
	} instr_t;

	function automatic instr_t mk(op_t o, raddr_t a, raddr_t b, raddr_t d);
		instr_t r;
		r.op = o; r.a = a; r.b = b; r.d = d;
		return r;
	endfunction

	// microprogram of one filter step
	function automatic instr_t prog(logic [PC_W-1:0] pc);
		instr_t r;
		r = mk(OP_MOV, R_X, R_X, R_X);
		case (pc)
			7'd0:  r = mk(OP_MUL, R_DT, R_DT, R_DT2);
			7'd1:  r = mk(OP_HALF, R_DT2, R_DT2, R_H);
			7'd2:  r = mk(OP_MUL, R_H, R_DT, R_Q3);
			7'd3:  r = mk(OP_MUL, R_H, R_H, R_Q4);
			7'd4:  r = mk(OP_SUB, R_AM, R_B, R_X);
			7'd5:  r = mk(OP_MUL, R_X, R_DT, R_X);
			7'd6:  r = mk(OP_ADD, R_V, R_X, R_V);
			7'd7:  r = mk(OP_MUL, R_V, R_DT, R_X);
			7'd8:  r = mk(OP_ADD, R_Z, R_X, R_Z);
			// first row t0..t2
			7'd9:  r = mk(OP_MUL, R_DT, R_P3, R_X);
			7'd10: r = mk(OP_ADD, R_P0, R_X, R_X);
			7'd11: r = mk(OP_MUL, R_H, R_P6, R_Y);
			7'd12: r = mk(OP_SUB, R_X, R_Y, R_T0);
			7'd13: r = mk(OP_MUL, R_DT, R_P4, R_X);
			7'd14: r = mk(OP_ADD, R_P1, R_X, R_X);
			7'd15: r = mk(OP_MUL, R_H, R_P7, R_Y);
			7'd16: r = mk(OP_SUB, R_X, R_Y, R_T1);
			7'd17: r = mk(OP_MUL, R_DT, R_P5, R_X);
			7'd18: r = mk(OP_ADD, R_P2, R_X, R_X);
			7'd19: r = mk(OP_MUL, R_H, R_P8, R_Y);
			7'd20: r = mk(OP_SUB, R_X, R_Y, R_T2);
			// second row in place: P3..P5 become t10..t12
			7'd21: r = mk(OP_MUL, R_DT, R_P6, R_X);
			7'd22: r = mk(OP_SUB, R_P3, R_X, R_P3);
			7'd23: r = mk(OP_MUL, R_DT, R_P7, R_X);
			7'd24: r = mk(OP_SUB, R_P4, R_X, R_P4);
			7'd25: r = mk(OP_MUL, R_DT, R_P8, R_X);
			7'd26: r = mk(OP_SUB, R_P5, R_X, R_P5);
			// right multiply, row 0
			7'd27: r = mk(OP_MUL, R_DT, R_T1, R_X);
			7'd28: r = mk(OP_ADD, R_T0, R_X, R_X);
			7'd29: r = mk(OP_MUL, R_H, R_T2, R_Y);
			7'd30: r = mk(OP_SUB, R_X, R_Y, R_P0);
			7'd31: r = mk(OP_MUL, R_DT, R_T2, R_X);
			7'd32: r = mk(OP_SUB, R_T1, R_X, R_P1);
			7'd33: r = mk(OP_MOV, R_T2, R_T2, R_P2);
			// row 1
			7'd34: r = mk(OP_MUL, R_DT, R_P4, R_X);
			7'd35: r = mk(OP_ADD, R_P3, R_X, R_X);
			7'd36: r = mk(OP_MUL, R_H, R_P5, R_Y);
			7'd37: r = mk(OP_SUB, R_X, R_Y, R_P3);
			7'd38: r = mk(OP_MUL, R_DT, R_P5, R_X);
			7'd39: r = mk(OP_SUB, R_P4, R_X, R_P4);
			// row 2
			7'd40: r = mk(OP_MUL, R_DT, R_P7, R_X);
			7'd41: r = mk(OP_ADD, R_P6, R_X, R_X);
			7'd42: r = mk(OP_MUL, R_H, R_P8, R_Y);
			7'd43: r = mk(OP_SUB, R_X, R_Y, R_P6);
			7'd44: r = mk(OP_MUL, R_DT, R_P8, R_X);
			7'd45: r = mk(OP_SUB, R_P7, R_X, R_P7);
			// process noise
			7'd46: r = mk(OP_MUL, R_Q4, R_QA, R_X);
			7'd47: r = mk(OP_ADD, R_P0, R_X, R_P0);
			7'd48: r = mk(OP_MUL, R_Q3, R_QA, R_X);
			7'd49: r = mk(OP_ADD, R_P1, R_X, R_P1);
			7'd50: r = mk(OP_ADD, R_P3, R_X, R_P3);
			7'd51: r = mk(OP_MUL, R_DT2, R_QA, R_X);
			7'd52: r = mk(OP_ADD, R_P4, R_X, R_P4);
			7'd53: r = mk(OP_ADD, R_P8, R_QB, R_P8);
			// innovation and gains
			7'd54: r = mk(OP_SUB, R_ZM, R_Z, R_IN);
			7'd55: r = mk(OP_ADD, R_P0, R_RV, R_DEN);
			7'd56: r = mk(OP_DIV, R_P0, R_DEN, R_KZ);
			7'd57: r = mk(OP_DIV, R_P3, R_DEN, R_KV);
			7'd58: r = mk(OP_DIV, R_P6, R_DEN, R_KA);
			// state update
			7'd59: r = mk(OP_MUL, R_KZ, R_IN, R_X);
			7'd60: r = mk(OP_ADD, R_Z, R_X, R_Z);
			7'd61: r = mk(OP_MUL, R_KV, R_IN, R_X);
			7'd62: r = mk(OP_ADD, R_V, R_X, R_V);
			7'd63: r = mk(OP_MUL, R_KA, R_IN, R_X);
			7'd64: r = mk(OP_ADD, R_B, R_X, R_B);
			// covariance update, rows 1 and 2 before row 0
			7'd65: r = mk(OP_MUL, R_KV, R_P0, R_X);
			7'd66: r = mk(OP_SUB, R_P3, R_X, R_P3);
			7'd67: r = mk(OP_MUL, R_KV, R_P1, R_X);
			7'd68: r = mk(OP_SUB, R_P4, R_X, R_P4);
			7'd69: r = mk(OP_MUL, R_KV, R_P2, R_X);
			7'd70: r = mk(OP_SUB, R_P5, R_X, R_P5);
			7'd71: r = mk(OP_MUL, R_KA, R_P0, R_X);
			7'd72: r = mk(OP_SUB, R_P6, R_X, R_P6);
			7'd73: r = mk(OP_MUL, R_KA, R_P1, R_X);
			7'd74: r = mk(OP_SUB, R_P7, R_X, R_P7);
			7'd75: r = mk(OP_MUL, R_KA, R_P2, R_X);
			7'd76: r = mk(OP_SUB, R_P8, R_X, R_P8);
			7'd77: r = mk(OP_MUL, R_KZ, R_P0, R_T0);
			default: r = mk(OP_MOV, R_X, R_X, R_X);
		endcase
		return r;
	endfunction

endpackage

// File: hw/rtl/kavb_ctrl.sv
// controller: sequences the step microprogram and the handshakes
module kavb_ctrl import kavb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic load,
	output logic out_load,
	input  logic out_free,
	output cmd_t cmd,
	input  sts_t sts
);

	state_t            state_q;
	logic [PC_W-1:0]   pc_q;
	logic              fin_q;
	instr_t            ins;

	assign ins      = prog(fin_q ? PC_W'(NPROG) : pc_q);
	assign in_ready = (state_q == ST_IDLE);
	assign load     = in_valid && in_ready;
	assign out_load = (state_q == ST_OUT) && out_free;

	// command to the datapath; final row-0 update runs as six extra ops
	always_comb begin
		cmd.start = (state_q == ST_ISS);
		cmd.op = ins.op;
		cmd.a = ins.a;
		cmd.b = ins.b;
		cmd.d = ins.d;
		if (fin_q) begin
			case (pc_q)
				7'd0: begin cmd.op = OP_SUB; cmd.a = R_P0; cmd.b = R_T0; cmd.d = R_Y; end
				7'd1: begin cmd.op = OP_MUL; cmd.a = R_KZ; cmd.b = R_P1; cmd.d = R_X; end
				7'd2: begin cmd.op = OP_SUB; cmd.a = R_P1; cmd.b = R_X;  cmd.d = R_P1; end
				7'd3: begin cmd.op = OP_MUL; cmd.a = R_KZ; cmd.b = R_P2; cmd.d = R_X; end
				7'd4: begin cmd.op = OP_SUB; cmd.a = R_P2; cmd.b = R_X;  cmd.d = R_P2; end
				default: begin cmd.op = OP_MOV; cmd.a = R_Y; cmd.b = R_Y; cmd.d = R_P0; end
			endcase
		end
	end

	// step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= '0;
			fin_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (load) state_q <= ST_LOAD;
				ST_LOAD: begin
					pc_q <= '0;
					fin_q <= 1'b0;
					state_q <= ST_ISS;
				end
				ST_ISS: state_q <= ST_WAIT;
				ST_WAIT: if (!sts.busy) begin
					if (!fin_q && pc_q == PC_W'(NPROG - 1)) begin
						fin_q <= 1'b1;
						pc_q <= '0;
						state_q <= ST_ISS;
					end else if (fin_q && pc_q == PC_W'(5)) begin
						state_q <= ST_OUT;
					end else begin
						pc_q <= pc_q + 1'b1;
						state_q <= ST_ISS;
					end
				end
				ST_OUT: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: hw/rtl/kavb_dp.sv
// datapath: register file, saturating alu, multi-cycle multiplier and divider
module kavb_dp import kavb_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_BITS-1:0]     cfg_idx,
	input  logic [WORD_BITS-2:0]        cfg_data,
	input  logic                        load,
	input  logic signed [WORD_BITS-1:0] zm,
	input  logic signed [WORD_BITS-1:0] am,
	input  cmd_t                        cmd,
	output sts_t                        sts,
	output logic signed [WORD_BITS-1:0] z_est,
	output logic signed [WORD_BITS-1:0] v_est
);

	localparam int W   = WORD_BITS;
	localparam int HW  = (W + 1) / 2;
	localparam int PW  = 2 * W;
	localparam int QW  = W + FRAC_BITS;
	localparam int CW  = $clog2(QW + 1);
	localparam logic [W-1:0] WMAXU = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] WMINU = {1'b1, {(W-1){1'b0}}};

	// reset constants saturate to the positive word range
	function automatic logic [W-1:0] rst_word(input logic [63:0] v);
		return (v > 64'(WMAXU)) ? WMAXU : W'(v);
	endfunction

	localparam logic [W-1:0] ONE   = rst_word(64'd1 << FRAC_BITS);
	localparam logic [W-1:0] BIGV  = rst_word(64'd100000 << FRAC_BITS);
	localparam logic [W-2:0] DT_RST =
		(W-1)'(rst_word(((64'd2 << FRAC_BITS) + 64'd50) / 64'd100));
	localparam logic [W-2:0] RV_RST = (W-1)'(rst_word(64'd50 << FRAC_BITS));
	localparam logic [W-2:0] QA_RST =
		(W-1)'(rst_word(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10));
	localparam logic [W-2:0] QB_RST = (W-1)'(rst_word(64'd1 << FRAC_BITS));

	logic [W-1:0] rf_q [NREG];
	logic [W-2:0] dt_q, rv_q, qa_q, qb_q;

	// operand fetch
	logic [W-1:0] opa, opb;
	always_comb begin
		case (cmd.a)
			R_DT: opa = {1'b0, dt_q};
			R_RV: opa = {1'b0, rv_q};
			R_QA: opa = {1'b0, qa_q};
			R_QB: opa = {1'b0, qb_q};
			default: opa = rf_q[cmd.a];
		endcase
		case (cmd.b)
			R_DT: opb = {1'b0, dt_q};
			R_RV: opb = {1'b0, rv_q};
			R_QA: opb = {1'b0, qa_q};
			R_QB: opb = {1'b0, qb_q};
			default: opb = rf_q[cmd.b];
		endcase
	end

	// saturating add/sub
	logic [W:0]   sum_x;
	logic [W-1:0] alu_res;
	always_comb begin
		if (cmd.op == OP_SUB)
			sum_x = {opa[W-1], opa} - {opb[W-1], opb};
		else
			sum_x = {opa[W-1], opa} + {opb[W-1], opb};
		if (sum_x[W] != sum_x[W-1])
			alu_res = sum_x[W] ? WMINU : WMAXU;
		else
			alu_res = sum_x[W-1:0];
		case (cmd.op)
			OP_HALF: alu_res = {opa[W-1], opa[W-1:1]};
			OP_MOV:  alu_res = opa;
			default: ;
		endcase
	end

	// multi-cycle unit state
	logic           neg_q, mul_q, busy_q;
	raddr_t         dst_q;
	logic [W-1:0]   ma_q, mb_q;
	logic [1:0]     mstep_q;
	logic [PW-1:0]  acc_q;
	logic [CW-1:0]  cnt_q;
	logic [QW-1:0]  num_q, quo_q;
	logic [W:0]     rem_q;
	logic [W-1:0]   den_q;

	function automatic logic [W-1:0] mag(input logic [W-1:0] x);
		return x[W-1] ? (~x + 1'b1) : x;
	endfunction

	// partial product of one half-word pair
	logic [HW-1:0]   pa, pb;
	logic [2*HW-1:0] pp;
	logic [PW-1:0]   pp_sh;
	always_comb begin
		pa = mstep_q[1] ? HW'(ma_q >> HW) : ma_q[HW-1:0];
		pb = mstep_q[0] ? HW'(mb_q >> HW) : mb_q[HW-1:0];
		pp = pa * pb;
		pp_sh = PW'(pp) << (HW * (32'(mstep_q[1]) + 32'(mstep_q[0])));
	end

	// restoring divider step
	logic [W:0] rtry;
	logic [W:0] rsh;
	always_comb begin
		rsh  = {rem_q[W-1:0], num_q[QW-1]};
		rtry = rsh - {1'b0, den_q};
	end

	// saturated signed packing of an unsigned magnitude
	function automatic logic [W-1:0] pack(input logic n, input logic [PW-1:0] m);
		logic [PW-1:0] lim;
		logic [W-1:0]  v;
		lim = n ? PW'(WMINU) : PW'(WMAXU);
		v = (m > lim) ? lim[W-1:0] : m[W-1:0];
		return n ? (~v + 1'b1) : v;
	endfunction

	logic [PW-1:0] prod_sh;
	assign prod_sh = acc_q >> FRAC_BITS;

	assign sts.busy = busy_q;
	assign z_est = rf_q[R_Z];
	assign v_est = rf_q[R_V];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= DT_RST;
			rv_q <= RV_RST;
			qa_q <= QA_RST;
			qb_q <= QB_RST;
			busy_q <= 1'b0;
			neg_q <= 1'b0;
			mul_q <= 1'b0;
			dst_q <= R_X;
			ma_q <= '0;
			mb_q <= '0;
			mstep_q <= '0;
			acc_q <= '0;
			cnt_q <= '0;
			num_q <= '0;
			quo_q <= '0;
			rem_q <= '0;
			den_q <= '0;
			for (int i = 0; i < NREG; i++) rf_q[i] <= '0;
			rf_q[R_P0] <= ONE;
			rf_q[R_P4] <= ONE;
			rf_q[R_P8] <= BIGV;
		end else begin
			// configuration writes
			if (cfg_we) begin
				case (cfg_idx)
					REG_STEP_INTERVAL: dt_q <= cfg_data;
					REG_MEAS_VAR:      rv_q <= cfg_data;
					REG_ACCEL_VAR:     qa_q <= cfg_data;
					REG_BIAS_VAR:      qb_q <= cfg_data;
					default: ;
				endcase
			end
			if (load) begin
				rf_q[R_ZM] <= zm;
				rf_q[R_AM] <= am;
			end
			// issue
			if (cmd.start) begin
				dst_q <= cmd.d;
				neg_q <= opa[W-1] ^ opb[W-1];
				case (cmd.op)
					OP_MUL: begin
						busy_q <= 1'b1;
						mul_q <= 1'b1;
						ma_q <= mag(opa);
						mb_q <= mag(opb);
						mstep_q <= '0;
						acc_q <= '0;
					end
					OP_DIV: begin
						busy_q <= 1'b1;
						mul_q <= 1'b0;
						num_q <= QW'(mag(opa)) << FRAC_BITS;
						den_q <= mag(opb);
						rem_q <= '0;
						quo_q <= '0;
						cnt_q <= CW'(QW);
					end
					default: rf_q[cmd.d] <= alu_res;
				endcase
			end else if (busy_q) begin
				if (mul_q) begin
					// four half-word products, then scale
					if (mstep_q == 2'd3 && cnt_q == CW'(1)) begin
						rf_q[dst_q] <= pack(neg_q, prod_sh);
						busy_q <= 1'b0;
					end else begin
						acc_q <= acc_q + pp_sh;
						if (mstep_q == 2'd3) cnt_q <= CW'(1);
						else begin
							mstep_q <= mstep_q + 1'b1;
							cnt_q <= '0;
						end
					end
				end else begin
					// one quotient bit a cycle
					if (cnt_q == '0) begin
						rf_q[dst_q] <= (den_q == '0) ? '0 : pack(neg_q, PW'(quo_q));
						busy_q <= 1'b0;
					end else begin
						num_q <= num_q << 1;
						cnt_q <= cnt_q - 1'b1;
						if (!rtry[W]) begin
							rem_q <= rtry;
							quo_q <= {quo_q[QW-2:0], 1'b1};
						end else begin
							rem_q <= rsh;
							quo_q <= {quo_q[QW-2:0], 1'b0};
						end
					end
				end
			end
		end
	end

endmodule

// File: hw/rtl/kalman_altitude_velocity_bias.sv
// top level: altitude, velocity and accelerometer-bias kalman filter
//
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  input    | in_valid/in_ready, measured_*            | in
//  result   | out_valid/out_ready, filtered_*          | out
//  config   | cfg_we, cfg_index, cfg_data              | in
//
// one step runs 84 microinstructions: 43 alu ops, 38 multiplies on a shared
// half-word multiplier and 3 divides on a one-bit-a-cycle divider, between the
// load and the output; one item at a time.
// reset loads the default registers and the initial covariance at once.
// a result held in the output register stalls only the next item's end.
module kalman_altitude_velocity_bias import kavb_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [WORD_BITS-2:0]        cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [WORD_BITS-1:0] measured_altitude,
	input  logic signed [WORD_BITS-1:0] measured_accel,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [WORD_BITS-1:0] filtered_altitude,
	output logic signed [WORD_BITS-1:0] filtered_velocity
);

	cmd_t cmd;
	sts_t sts;
	logic load, out_load, out_free;
	logic signed [WORD_BITS-1:0] z_est, v_est;
	logic out_valid_q;
	logic signed [WORD_BITS-1:0] alt_q, vel_q;

	assign out_free = !out_valid_q || out_ready;

	kavb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.load(load), .out_load(out_load), .out_free(out_free), .cmd(cmd), .sts(sts)
	);

	kavb_dp #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_index),
		.cfg_data(cfg_data), .load(load), .zm(measured_altitude), .am(measured_accel),
		.cmd(cmd), .sts(sts), .z_est(z_est), .v_est(v_est)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			alt_q <= z_est;
			vel_q <= v_est;
		end
	end

	assign out_valid = out_valid_q;
	assign filtered_altitude = alt_q;
	assign filtered_velocity = vel_q;

endmodule

// File: hw/rtl/kavb_checker.sv
// port-level checker for the kalman filter, bound to the top level
`include "kalman_altitude_velocity_bias_defines.svh"
module kavb_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready
);

	// no new transfer while a step is in flight
	`KAVB_ASSERT_NXT(a_busy_after_in, in_valid && in_ready, !in_ready, "input taken twice")
	// a result never appears in the cycle after an input transfer
	`KAVB_ASSERT_NXT(a_no_fast_out, in_valid && in_ready, !out_valid || $past(out_valid), "early result")
	// a stalled result holds
	`KAVB_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")

endmodule

bind kalman_altitude_velocity_bias kavb_checker u_kavb_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready)
);
